// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/crcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// crcfp_pkg
// Types, constants and the CRC-16/MODBUS byte step for the frame parser.
// ----------------------------------------------------------------------------
package crcfp_pkg;

    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam int          HDR_BYTES  = 7;
    localparam int          MIN_FRAME  = 9;
    localparam int          LEN_W      = 7;
    localparam int          K_W        = 7;

    localparam logic [K_W-1:0] K_START0 = 7'd0;
    localparam logic [K_W-1:0] K_START1 = 7'd1;
    localparam logic [K_W-1:0] K_CMD    = 7'd2;
    localparam logic [K_W-1:0] K_SEQ_LO = 7'd3;
    localparam logic [K_W-1:0] K_SEQ_HI = 7'd4;
    localparam logic [K_W-1:0] K_LEN_LO = 7'd5;
    localparam logic [K_W-1:0] K_LEN_HI = 7'd6;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    localparam logic ADDR_START_FIRST  = 1'b0;
    localparam logic ADDR_START_SECOND = 1'b1;

    typedef struct packed {
        logic       is_pop;
        logic [7:0] rx_byte;
    } t_cmd;

    typedef struct packed {
        logic             frame_found;
        logic [7:0]       cmd_code;
        logic [15:0]      seq_number;
        logic [LEN_W-1:0] payload_length;
        logic [7:0]       payload_byte;
        logic             byte_valid;
        logic             last;
        logic [31:0]      crc_error_total;
        logic [31:0]      length_error_total;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_FETCH,
        S_USE,
        S_SFETCH,
        S_SUSE,
        S_NOFRAME,
        S_EMPTYF
    } t_eng_state;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/crc16_frame_parser_resync_unit.sv =====
// ----------------------------------------------------------------------------
// crc16_frame_parser_resync_unit
// Byte store with CRC-16/MODBUS frame scan and resynchronization.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue (push/full): req_type 0 stores rx_byte, req_type 1 asks for
//   the next frame. Up to four requests wait in a command queue.
//   Result queue (empty/pop): results of a pop, oldest first; last marks the
//   final result of that pop. A two-entry result queue decouples the reader.
// Timing:
//   A push is carried out as soon as it reaches the engine.
//   A pop reads the store one byte at a time (address, then
//   registered read data), both while it scans for a frame and while
//   it streams the payload bytes.
// Reset:
//   Clears the store fill, head and both error counters; start bytes return
//   to 0xAA / 0x55. No clearing pass: unread store entries are never read.
// Stalls:
//   While the result queue is full the engine holds; commands keep queuing
//   until the command queue fills, then full is raised.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crc16_frame_parser_resync_unit #(
    parameter int MAX_PAYLOAD = 64,
    parameter int BUF_DEPTH   = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_req_type,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic        o_frame_found,
    output logic [7:0]  o_cmd_code,
    output logic [15:0] o_seq_number,
    output logic [6:0]  o_payload_length,
    output logic [7:0]  o_payload_byte,
    output logic        o_byte_valid,
    output logic        o_last,
    output logic [31:0] o_crc_error_total,
    output logic [31:0] o_length_error_total,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int CMD_W = $bits(crcfp_pkg::t_cmd);
    localparam int RES_W = $bits(crcfp_pkg::t_result);

    logic [7:0] r_start_first, r_start_second;
    crcfp_pkg::t_cmd    w_cmd_in, w_cmd_out;
    crcfp_pkg::t_result w_res_in, w_res_out;
    logic w_cmd_empty, w_cmd_ready, w_res_push, w_res_full;
    logic w_nf_res, w_byte_res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == crcfp_pkg::ADDR_START_SECOND) ?
                    {24'h0, r_start_second} : {24'h0, r_start_first};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_first  <= 8'hAA;
            r_start_second <= 8'h55;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == crcfp_pkg::ADDR_START_FIRST) begin
                r_start_first <= pwdata[7:0];
            end else begin
                r_start_second <= pwdata[7:0];
            end
        end
    end

    assign w_cmd_in.is_pop  = i_req_type;
    assign w_cmd_in.rx_byte = i_rx_byte;

    crcfp_fifo #(.WIDTH(CMD_W), .DEPTH(4)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_cmd_in),
        .o_full  (full),
        .i_pop   (w_cmd_ready),
        .o_data  (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    crcfp_engine #(.MAX_PAYLOAD(MAX_PAYLOAD), .BUF_DEPTH(BUF_DEPTH)) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (!w_cmd_empty),
        .i_cmd          (w_cmd_out),
        .o_cmd_ready    (w_cmd_ready),
        .o_res_push     (w_res_push),
        .o_res          (w_res_in),
        .i_res_full     (w_res_full),
        .i_start_first  (r_start_first),
        .i_start_second (r_start_second)
    );

    crcfp_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    assign o_frame_found        = w_res_out.frame_found;
    assign o_cmd_code           = w_res_out.cmd_code;
    assign o_seq_number         = w_res_out.seq_number;
    assign o_payload_length     = w_res_out.payload_length;
    assign o_payload_byte       = w_res_out.payload_byte;
    assign o_byte_valid         = w_res_out.byte_valid;
    assign o_last               = w_res_out.last;
    assign o_crc_error_total    = w_res_out.crc_error_total;
    assign o_length_error_total = w_res_out.length_error_total;

    assign w_nf_res   = !empty && !o_frame_found;
    assign w_byte_res = !empty && o_byte_valid;

    `ASSERT_CLK(a_noframe_shape, w_nf_res |-> (o_last && !o_byte_valid), "bad no-frame result")
    `ASSERT_CLK(a_valid_byte_shape, w_byte_res |-> (o_frame_found && o_payload_length != 7'd0), "stray byte")
    `ASSERT_CLK(a_res_no_overflow, w_res_push |-> !w_res_full, "result queue overflow")
endmodule

// ===== rtl/core/crcfp_fifo.sv =====
// ----------------------------------------------------------------------------
// crcfp_fifo
// Small register FIFO used for the command queue and the result queue.
// ----------------------------------------------------------------------------
module crcfp_fifo #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// ===== rtl/core/crcfp_engine.sv =====
// ----------------------------------------------------------------------------
// crcfp_engine
// Back end: byte store, frame scan with CRC check, payload streaming.
// ----------------------------------------------------------------------------
module crcfp_engine #(
    parameter int MAX_PAYLOAD = 64,
    parameter int BUF_DEPTH   = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  crcfp_pkg::t_cmd   i_cmd,
    output logic              o_cmd_ready,
    output logic              o_res_push,
    output crcfp_pkg::t_result o_res,
    input  logic              i_res_full,
    input  logic [7:0]        i_start_first,
    input  logic [7:0]        i_start_second
);
    localparam int AW = $clog2(BUF_DEPTH);
    localparam int FW = $clog2(BUF_DEPTH + 1);
    localparam int KW = crcfp_pkg::K_W;

    crcfp_pkg::t_eng_state r_state, n_state;

    logic [7:0]  r_mem [BUF_DEPTH];
    logic [7:0]  r_rdata;
    logic        mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]  mem_wdata;

    logic [AW-1:0] r_head, n_head;
    logic [FW-1:0] r_fill, n_fill;
    logic [KW-1:0] r_k, n_k;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_cmd, n_cmd;
    logic [15:0] r_seq, n_seq;
    logic [crcfp_pkg::LEN_W-1:0] r_len, n_len;
    logic [7:0]  r_len_lo, n_len_lo;
    logic [7:0]  r_got_lo, n_got_lo;
    logic [31:0] r_crc_cnt, n_crc_cnt;
    logic [31:0] r_len_cnt, n_len_cnt;

    logic [15:0] w_len_full;
    logic        w_oversize, w_short, w_crc_ok, w_stream_last, w_len_zero;
    logic [FW:0] w_need, w_total;
    logic [15:0] w_crc_next;
    logic [KW-1:0] w_k_got_lo, w_k_got_hi, w_k_pay_end;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] head, input logic [AW:0] off);
        logic [AW:0] s;
        s = {1'b0, head} + off;
        if (s >= (AW+1)'(BUF_DEPTH)) begin
            s = s - (AW+1)'(BUF_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign w_len_full  = {r_rdata, r_len_lo};
    assign w_oversize  = (w_len_full > 16'(MAX_PAYLOAD));
    assign w_need      = (FW+1)'(crcfp_pkg::MIN_FRAME) + (FW+1)'(w_len_full[6:0]);
    assign w_short     = ({1'b0, r_fill} < w_need);
    assign w_crc_next  = crcfp_pkg::crc_byte(r_crc, r_rdata);
    assign w_crc_ok    = ({r_rdata, r_got_lo} == r_crc);
    assign w_k_pay_end = KW'(crcfp_pkg::HDR_BYTES) + KW'(r_len);
    assign w_k_got_lo  = w_k_pay_end;
    assign w_k_got_hi  = w_k_pay_end + 1'b1;
    assign w_stream_last = (r_k == w_k_pay_end - 1'b1);
    assign w_len_zero  = (r_len == '0);
    assign w_total     = (FW+1)'(crcfp_pkg::MIN_FRAME) + (FW+1)'(r_len);

    // byte store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            crcfp_pkg::S_IDLE: begin
                if (i_cmd_valid && i_cmd.is_pop == crcfp_pkg::REQ_POP) begin
                    n_state = crcfp_pkg::S_CHECK;
                end
            end
            crcfp_pkg::S_CHECK: begin
                n_state = (r_fill < FW'(crcfp_pkg::MIN_FRAME)) ?
                          crcfp_pkg::S_NOFRAME : crcfp_pkg::S_FETCH;
            end
            crcfp_pkg::S_FETCH: n_state = crcfp_pkg::S_USE;
            crcfp_pkg::S_USE: begin
                if (r_k == crcfp_pkg::K_START0) begin
                    n_state = (r_rdata != i_start_first) ? crcfp_pkg::S_CHECK
                                                         : crcfp_pkg::S_FETCH;
                end else if (r_k == crcfp_pkg::K_START1) begin
                    n_state = (r_rdata != i_start_second) ? crcfp_pkg::S_CHECK
                                                          : crcfp_pkg::S_FETCH;
                end else if (r_k == crcfp_pkg::K_LEN_HI) begin
                    if (w_oversize) begin
                        n_state = crcfp_pkg::S_CHECK;
                    end else if (w_short) begin
                        n_state = crcfp_pkg::S_NOFRAME;
                    end else begin
                        n_state = crcfp_pkg::S_FETCH;
                    end
                end else if (r_k < crcfp_pkg::K_LEN_HI) begin
                    n_state = crcfp_pkg::S_FETCH;
                end else if (r_k == w_k_got_hi) begin
                    if (!w_crc_ok) begin
                        n_state = crcfp_pkg::S_CHECK;
                    end else if (w_len_zero) begin
                        n_state = crcfp_pkg::S_EMPTYF;
                    end else begin
                        n_state = crcfp_pkg::S_SFETCH;
                    end
                end else begin
                    n_state = crcfp_pkg::S_FETCH;
                end
            end
            crcfp_pkg::S_SFETCH: n_state = crcfp_pkg::S_SUSE;
            crcfp_pkg::S_SUSE: begin
                if (!i_res_full) begin
                    n_state = w_stream_last ? crcfp_pkg::S_IDLE : crcfp_pkg::S_SFETCH;
                end
            end
            crcfp_pkg::S_NOFRAME, crcfp_pkg::S_EMPTYF: begin
                if (!i_res_full) begin
                    n_state = crcfp_pkg::S_IDLE;
                end
            end
            default: n_state = crcfp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_head    = r_head;
        n_fill    = r_fill;
        n_k       = r_k;
        n_crc     = r_crc;
        n_cmd     = r_cmd;
        n_seq     = r_seq;
        n_len     = r_len;
        n_len_lo  = r_len_lo;
        n_got_lo  = r_got_lo;
        n_crc_cnt = r_crc_cnt;
        n_len_cnt = r_len_cnt;
        mem_we    = 1'b0;
        mem_waddr = slot(r_head, (AW+1)'(r_fill));
        mem_wdata = i_cmd.rx_byte;
        mem_re    = 1'b0;
        mem_raddr = slot(r_head, (AW+1)'(r_k));
        o_cmd_ready = 1'b0;
        o_res_push  = 1'b0;
        o_res       = '0;
        o_res.crc_error_total    = r_crc_cnt;
        o_res.length_error_total = r_len_cnt;
        o_res.last  = 1'b1;

        case (r_state)
            crcfp_pkg::S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid && i_cmd.is_pop == crcfp_pkg::REQ_PUSH) begin
                    mem_we = 1'b1;
                    if (r_fill == FW'(BUF_DEPTH)) begin
                        // full: overwrite the oldest byte
                        mem_waddr = r_head;
                        n_head    = slot(r_head, (AW+1)'(1));
                    end else begin
                        n_fill = r_fill + 1'b1;
                    end
                end
            end
            crcfp_pkg::S_CHECK: begin
                n_k   = crcfp_pkg::K_START0;
                n_crc = crcfp_pkg::CRC_INIT;
            end
            crcfp_pkg::S_FETCH, crcfp_pkg::S_SFETCH: begin
                mem_re = 1'b1;
            end
            crcfp_pkg::S_USE: begin
                n_k = r_k + 1'b1;
                if (r_k == crcfp_pkg::K_START0 || r_k == crcfp_pkg::K_START1) begin
                    if ((r_k == crcfp_pkg::K_START0 && r_rdata != i_start_first) ||
                        (r_k == crcfp_pkg::K_START1 && r_rdata != i_start_second)) begin
                        n_head = slot(r_head, (AW+1)'(1));
                        n_fill = r_fill - 1'b1;
                    end
                end else if (r_k <= crcfp_pkg::K_LEN_HI) begin
                    n_crc = w_crc_next;
                    if (r_k == crcfp_pkg::K_CMD) begin
                        n_cmd = r_rdata;
                    end else if (r_k == crcfp_pkg::K_SEQ_LO) begin
                        n_seq[7:0] = r_rdata;
                    end else if (r_k == crcfp_pkg::K_SEQ_HI) begin
                        n_seq[15:8] = r_rdata;
                    end else if (r_k == crcfp_pkg::K_LEN_LO) begin
                        n_len_lo = r_rdata;
                    end else begin
                        n_len = w_len_full[crcfp_pkg::LEN_W-1:0];
                        if (w_oversize) begin
                            n_len_cnt = r_len_cnt + 1'b1;
                            n_head    = slot(r_head, (AW+1)'(1));
                            n_fill    = r_fill - 1'b1;
                        end
                    end
                end else if (r_k < w_k_got_lo) begin
                    n_crc = w_crc_next;
                end else if (r_k == w_k_got_lo) begin
                    n_got_lo = r_rdata;
                end else begin
                    if (!w_crc_ok) begin
                        n_crc_cnt = r_crc_cnt + 1'b1;
                        n_head    = slot(r_head, (AW+1)'(1));
                        n_fill    = r_fill - 1'b1;
                    end else begin
                        n_k = KW'(crcfp_pkg::HDR_BYTES);
                    end
                end
            end
            crcfp_pkg::S_SUSE, crcfp_pkg::S_EMPTYF: begin
                o_res.frame_found    = 1'b1;
                o_res.cmd_code       = r_cmd;
                o_res.seq_number     = r_seq;
                o_res.payload_length = r_len;
                if (r_state == crcfp_pkg::S_SUSE) begin
                    o_res.payload_byte = r_rdata;
                    o_res.byte_valid   = 1'b1;
                    o_res.last         = w_stream_last;
                end
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_k        = r_k + 1'b1;
                    if (o_res.last) begin
                        // remove the whole frame
                        if ({1'b0, r_fill} == w_total) begin
                            n_fill = '0;
                        end else begin
                            n_head = slot(r_head, w_total[AW:0]);
                            n_fill = r_fill - w_total[FW-1:0];
                        end
                    end
                end
            end
            crcfp_pkg::S_NOFRAME: begin
                o_res_push = !i_res_full;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= crcfp_pkg::S_IDLE;
            r_head    <= '0;
            r_fill    <= '0;
            r_crc_cnt <= '0;
            r_len_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_fill    <= n_fill;
            r_crc_cnt <= n_crc_cnt;
            r_len_cnt <= n_len_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_crc    <= n_crc;
        r_cmd    <= n_cmd;
        r_seq    <= n_seq;
        r_len    <= n_len;
        r_len_lo <= n_len_lo;
        r_got_lo <= n_got_lo;
    end
endmodule
